// ===== hdl/ldf_pkg.sv =====
package ldf_pkg;

    localparam int unsigned HDR_W       = 3;
    localparam int unsigned LEN_W       = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    localparam logic [HDR_W-1:0] HDR_DEFAULT = 3'd2;
    localparam logic [HDR_W-1:0] HDR_MIN     = 3'd1;
    localparam logic [HDR_W-1:0] HDR_MAX     = 3'd4;

    // register index, taken from paddr above the byte offset
    typedef enum logic {
        REG_HEADER_BYTES = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_start;
        logic              frame_end;
        logic [LEN_W-1:0]  frame_length;
    } frame_item_t;

    typedef struct packed {
        logic push;
        logic full;
    } queue_ctrl_t;

    function automatic logic [HDR_W-1:0] effective_size(input logic [HDR_W-1:0] hdr);
        logic [HDR_W-1:0] size;
        size = hdr;
        if (hdr < HDR_MIN || hdr > HDR_MAX) begin
            size = HDR_DEFAULT;
        end
        return size;
    endfunction

endpackage

// ===== hdl/ldf_front.sv =====
module ldf_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ldf_pkg::BYTE_W-1:0]          s_data_byte,
    input  logic [ldf_pkg::HDR_W-1:0]           header_bytes,
    input  logic                                queue_full,
    output ldf_pkg::queue_ctrl_t                ctrl,
    output ldf_pkg::frame_item_t                item
);

    logic                            in_payload_reg, in_payload_next;
    logic [ldf_pkg::HDR_W-1:0]       header_count_reg, header_count_next;
    logic [ldf_pkg::LEN_W-1:0]       length_accum_reg, length_accum_next;
    logic [ldf_pkg::LEN_W-1:0]       bytes_left_reg, bytes_left_next;
    logic                            at_first_reg, at_first_next;

    logic                            accept;
    logic [ldf_pkg::HDR_W-1:0]       count_inc;
    logic [ldf_pkg::LEN_W-1:0]       accum_base;
    logic [ldf_pkg::LEN_W-1:0]       accum_shift;
    logic                            header_done;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    assign count_inc   = header_count_reg + ldf_pkg::HDR_W'(1);
    assign accum_base  = (header_count_reg == '0) ? '0 : length_accum_reg;
    assign accum_shift = {accum_base[ldf_pkg::LEN_W-ldf_pkg::BYTE_W-1:0], s_data_byte};
    assign header_done = count_inc >= ldf_pkg::effective_size(header_bytes);

    always_comb begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        at_first_next     = at_first_reg;
        if (accept) begin
            if (!in_payload_reg) begin
                length_accum_next = accum_shift;
                header_count_next = count_inc;
                if (header_done) begin
                    header_count_next = '0;
                    // drop a zero-length header and go on with the next one
                    if (accum_shift != '0) begin
                        in_payload_next = 1'b1;
                        bytes_left_next = accum_shift;
                        at_first_next   = 1'b1;
                    end
                end
            end else begin
                at_first_next   = 1'b0;
                bytes_left_next = bytes_left_reg - ldf_pkg::LEN_W'(1);
                if (bytes_left_reg == ldf_pkg::LEN_W'(1)) begin
                    in_payload_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= '0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
            at_first_reg     <= 1'b0;
        end else begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            length_accum_reg <= length_accum_next;
            bytes_left_reg   <= bytes_left_next;
            at_first_reg     <= at_first_next;
        end
    end

    assign ctrl.push          = accept && in_payload_reg;
    assign ctrl.full          = queue_full;
    assign item.payload_byte  = s_data_byte;
    assign item.frame_start   = at_first_reg;
    assign item.frame_end     = (bytes_left_reg == ldf_pkg::LEN_W'(1));
    assign item.frame_length  = length_accum_reg;

endmodule

// ===== hdl/ldf_queue.sv =====
module ldf_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ldf_pkg::queue_ctrl_t                ctrl,
    input  ldf_pkg::frame_item_t                push_item,
    output logic                                full,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ldf_pkg::BYTE_W-1:0]          m_payload_byte,
    output logic                                m_frame_start,
    output logic                                m_frame_end,
    output logic [ldf_pkg::LEN_W-1:0]           m_frame_length
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ldf_pkg::frame_item_t    entries_reg [DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    do_push, do_pop;
    ldf_pkg::frame_item_t    head;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign m_valid = (count_reg != '0);
    assign do_push = ctrl.push && !ctrl.full;
    assign do_pop  = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head           = entries_reg[rd_ptr_reg];
    assign m_payload_byte = head.payload_byte;
    assign m_frame_start  = head.frame_start;
    assign m_frame_end    = head.frame_end;
    assign m_frame_length = head.frame_length;

endmodule

// ===== hdl/length_prefix_deframer_top.sv =====
// A payload beat accepted on s_ is registered in the output queue and reaches m_ from there.
// Throughput: one byte per cycle; header bytes are consumed at the same rate.
// The output queue (QUEUE_DEPTH entries) absorbs m_ready stalls; s_ready
// drops only while it is full.
// Reset (synchronous, aresetn low): parser expects a header, queue empty,
// header_bytes = 2.
module length_prefix_deframer_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ldf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [ldf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [ldf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ldf_pkg::BYTE_W-1:0]          s_data_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ldf_pkg::BYTE_W-1:0]          m_payload_byte,
    output logic                                m_frame_start,
    output logic                                m_frame_end,
    output logic [ldf_pkg::LEN_W-1:0]           m_frame_length
);

    logic [ldf_pkg::HDR_W-1:0]   header_bytes_reg;
    ldf_pkg::reg_index_t         reg_index;
    logic                        queue_full;
    ldf_pkg::queue_ctrl_t        ctrl;
    ldf_pkg::frame_item_t        item;

    assign pready    = 1'b1;
    assign reg_index = ldf_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_bytes_reg <= ldf_pkg::HDR_DEFAULT;
        end else if (psel && penable && pwrite && pready
                     && reg_index == ldf_pkg::REG_HEADER_BYTES) begin
            header_bytes_reg <= pwdata[ldf_pkg::HDR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == ldf_pkg::REG_HEADER_BYTES) begin
            prdata = ldf_pkg::APB_DATA_W'(header_bytes_reg);
        end
    end

    ldf_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .header_bytes (header_bytes_reg),
        .queue_full   (queue_full),
        .ctrl         (ctrl),
        .item         (item)
    );

    ldf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .push_item      (item),
        .full           (queue_full),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload_byte (m_payload_byte),
        .m_frame_start  (m_frame_start),
        .m_frame_end    (m_frame_end),
        .m_frame_length (m_frame_length)
    );

endmodule
